>>> design/tgc_pkg.sv
package tgc_pkg;

   // Widths of the sample fields and the threshold registers.
   localparam int unsigned SAMPLE_W    = 16;
   localparam int unsigned THRESH_W    = 15;
   localparam int unsigned CSR_INDEX_W = 2;

   // Reset values of the threshold registers.
   localparam logic [THRESH_W-1:0] LATERAL_RESET  = 15'd4000;
   localparam logic [THRESH_W-1:0] VERTICAL_RESET = 15'd5000;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] REG_LATERAL  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_VERTICAL = 2'd1;

   // Sample classes and latched gestures share one code space.
   typedef enum logic [2:0] {
      GST_UNKNOWN = 3'd0,
      GST_LEFT    = 3'd1,
      GST_RIGHT   = 3'd2,
      GST_UP      = 3'd3,
      GST_DOWN    = 3'd4,
      GST_FORWARD = 3'd5,
      GST_BACK    = 3'd6
   } gesture_type;

   // Latch state as seen after one sample has been processed.
   typedef struct packed {
      logic        valid;
      gesture_type gesture;
   } latch_type;

endpackage

>>> design/tgc_classify.sv
module tgc_classify import tgc_pkg::*; (
   input  logic signed [SAMPLE_W-1:0] accel_x,
   input  logic signed [SAMPLE_W-1:0] accel_y,
   input  logic        [THRESH_W-1:0] lateral_threshold,
   input  logic        [THRESH_W-1:0] vertical_threshold,
   output gesture_type                sample_class
);

   // One extra bit holds both the sample and the negated threshold.
   logic signed [SAMPLE_W:0] x_ext;
   logic signed [SAMPLE_W:0] y_ext;
   logic signed [SAMPLE_W:0] lat_pos;
   logic signed [SAMPLE_W:0] lat_neg;
   logic signed [SAMPLE_W:0] vert_pos;
   logic signed [SAMPLE_W:0] vert_neg;

   assign x_ext    = {accel_x[SAMPLE_W-1], accel_x};
   assign y_ext    = {accel_y[SAMPLE_W-1], accel_y};
   assign lat_pos  = $signed({{(SAMPLE_W+1-THRESH_W){1'b0}}, lateral_threshold});
   assign vert_pos = $signed({{(SAMPLE_W+1-THRESH_W){1'b0}}, vertical_threshold});
   assign lat_neg  = -lat_pos;
   assign vert_neg = -vert_pos;

   // Y is tested before X; all comparisons are strict.
   always_comb begin
      priority if (y_ext > lat_pos) begin
         sample_class = GST_LEFT;
      end else if (y_ext < lat_neg) begin
         sample_class = GST_RIGHT;
      end else if (x_ext > vert_pos) begin
         sample_class = GST_UP;
      end else if (x_ext < vert_neg) begin
         sample_class = GST_DOWN;
      end else begin
         sample_class = GST_UNKNOWN;
      end
   end

endmodule

>>> design/tgc_tracker.sv
module tgc_tracker import tgc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic        consumed,
   input  gesture_type sample_class,
   output latch_type   latch_next
);

   // Only the two history entries older than the newest one are ever
   // compared, so the ring is kept as those two entries.
   gesture_type prev1_ff, prev1_in;
   gesture_type prev2_ff, prev2_in;
   latch_type   latch_ff;

   latch_type   latch_base;
   logic        repeat_tilt;

   // A consumed sample releases the latch before it is evaluated.
   always_comb begin
      if (consumed) begin
         latch_base.valid   = 1'b0;
         latch_base.gesture = GST_UNKNOWN;
      end else begin
         latch_base = latch_ff;
      end
   end

   assign repeat_tilt = (prev1_ff == sample_class) && (prev2_ff == sample_class)
                        && ((sample_class == GST_UP) || (sample_class == GST_DOWN));

   // Latch update and history shift for this sample.
   always_comb begin
      latch_next = latch_base;
      prev1_in   = sample_class;
      prev2_in   = prev1_ff;
      if (!latch_base.valid) begin
         if (repeat_tilt) begin
            latch_next.valid   = 1'b1;
            latch_next.gesture = (sample_class == GST_UP) ? GST_FORWARD : GST_BACK;
            // The two older entries of the run go back to unknown.
            prev2_in = GST_UNKNOWN;
         end else if (sample_class != GST_UNKNOWN) begin
            latch_next.valid   = 1'b1;
            latch_next.gesture = sample_class;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev1_ff <= GST_UNKNOWN;
         prev2_ff <= GST_UNKNOWN;
         latch_ff <= '{valid: 1'b0, gesture: GST_UNKNOWN};
      end else if (step) begin
         prev1_ff <= prev1_in;
         prev2_ff <= prev2_in;
         latch_ff <= latch_next;
      end
   end

endmodule

>>> design/tilt_gesture_classifier.sv
// Tilt gesture classifier. Each accelerometer sample (X, Y) is classified as
// left, right, up, down or unknown against two programmable thresholds, and a
// gesture is latched until a later sample arrives with consumed set. Three up
// or three down samples in a row while nothing is latched latch forward or
// back. One sample is accepted every clock cycle unless the result side stalls;
// a sample passes an input register and then a result register before its
// result is offered, and a stalled result consumer holds back the input side.
// Threshold writes take effect immediately and are taken in any cycle; they
// are meant to be made while no sample is in flight.
module tilt_gesture_classifier import tgc_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   // Sample channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_accel_x,
   input  logic signed [SAMPLE_W-1:0] req_accel_y,
   input  logic                       req_consumed,
   // Result channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_gesture_valid,
   output logic        [2:0]          rsp_gesture,
   output logic        [2:0]          rsp_sample_class,
   // Configuration channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic     [CSR_INDEX_W-1:0] csr_index,
   input  logic        [THRESH_W-1:0] csr_wdata
);

   logic [THRESH_W-1:0] lateral_ff;
   logic [THRESH_W-1:0] vertical_ff;

   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] accel_x_ff;
   logic signed [SAMPLE_W-1:0] accel_y_ff;
   logic                       consumed_ff;

   logic        out_valid_ff;
   latch_type   out_latch_ff;
   gesture_type out_class_ff;

   logic        result_load;
   gesture_type sample_class;
   latch_type   latch_next;

   // Threshold registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lateral_ff  <= LATERAL_RESET;
         vertical_ff <= VERTICAL_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_LATERAL) begin
            lateral_ff <= csr_wdata;
         end
         if (csr_index == REG_VERTICAL) begin
            vertical_ff <= csr_wdata;
         end
      end
   end

   // The result register loads when it is empty or its transfer completes.
   assign result_load = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready   = !in_valid_ff || result_load;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         accel_x_ff  <= req_accel_x;
         accel_y_ff  <= req_accel_y;
         consumed_ff <= req_consumed;
      end
   end

   tgc_classify u_classify (
      .accel_x            (accel_x_ff),
      .accel_y            (accel_y_ff),
      .lateral_threshold  (lateral_ff),
      .vertical_threshold (vertical_ff),
      .sample_class       (sample_class)
   );

   tgc_tracker u_tracker (
      .clock        (clock),
      .reset        (reset),
      .step         (result_load),
      .consumed     (consumed_ff),
      .sample_class (sample_class),
      .latch_next   (latch_next)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         out_latch_ff <= latch_next;
         out_class_ff <= sample_class;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_gesture_valid = out_latch_ff.valid;
   assign rsp_gesture       = out_latch_ff.gesture;
   assign rsp_sample_class  = out_class_ff;

endmodule

>>> design/tgc_checker.sv
module tgc_checker import tgc_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_gesture_valid,
   input logic        [2:0]          rsp_gesture,
   input logic        [2:0]          rsp_sample_class
);

   // No result is offered in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A stalled result holds its fields.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_gesture_valid)
         && $stable(rsp_gesture) && $stable(rsp_sample_class))
      else $error("stalled result changed");

   // Without a latched gesture the gesture field reads unknown.
   a_idle_gesture: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gesture_valid |-> rsp_gesture == GST_UNKNOWN)
      else $error("gesture shown without latch");

   // A known class always latches when nothing is held, so an empty latch
   // can only follow an unknown sample.
   a_known_latches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_gesture_valid |-> rsp_sample_class == GST_UNKNOWN)
      else $error("known sample left latch empty");

endmodule

bind tilt_gesture_classifier tgc_checker u_checker (.*);

>>> verif/tb_tilt_gesture_classifier.sv
module tb_tilt_gesture_classifier;
   import tgc_pkg::*;

   localparam int HIST_DEPTH   = 4;
   localparam int DRAIN_CYCLES = 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   // Indexes past the register list; writes to them must change nothing.
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct {
      logic        gesture_valid;
      gesture_type gesture;
      gesture_type sample_class;
   } tilt_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid    = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_accel_x  = '0;
   logic signed [SAMPLE_W-1:0] req_accel_y  = '0;
   logic                       req_consumed = 1'b0;

   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_gesture_valid;
   logic [2:0] rsp_gesture;
   logic [2:0] rsp_sample_class;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_LATERAL;
   logic [THRESH_W-1:0]    csr_wdata = '0;

   // Local copy of the classifier state and its thresholds.
   logic [THRESH_W-1:0] lat_thr   = LATERAL_RESET;
   logic [THRESH_W-1:0] vert_thr  = VERTICAL_RESET;
   gesture_type         cls_hist [HIST_DEPTH] = '{default: GST_UNKNOWN};
   logic [1:0]          hist_ptr  = 2'd0;
   logic                latch_on  = 1'b0;
   gesture_type         latch_gst = GST_UNKNOWN;

   tilt_result_type expected_results [$];

   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int mismatch_count = 0;
   int cycles_run     = 0;

   // A hold-off is requested by bumping stall_requests; the receiver owns the countdown.
   int stall_requests = 0;
   int stall_len      = 0;
   int stall_taken    = 0;
   int stall_left     = 0;

   tilt_gesture_classifier dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_accel_x       (req_accel_x),
      .req_accel_y       (req_accel_y),
      .req_consumed      (req_consumed),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_gesture_valid (rsp_gesture_valid),
      .rsp_gesture       (rsp_gesture),
      .rsp_sample_class  (rsp_sample_class),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #2 clock = ~clock;

   // Watchdog: a run that takes too long is a failure.
   initial begin
      while (cycles_run < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles_run++;
      end
      $display("tilt_gesture_classifier test failed");
      $finish;
   end

   // Result receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_taken != stall_requests) begin
         stall_taken = stall_requests;
         stall_left  = stall_len;
         rsp_ready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // Each result transfer is compared with the oldest expectation.
   always @(posedge clock) begin
      tilt_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
               $display("unexpected result: valid %0d gesture %0d class %0d",
                        rsp_gesture_valid, rsp_gesture, rsp_sample_class);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_gesture_valid !== want.gesture_valid ||
                rsp_gesture !== want.gesture ||
                rsp_sample_class !== want.sample_class) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT) begin
                  $display("mismatch: expected valid %0d gesture %0d class %0d, got %0d %0d %0d",
                           want.gesture_valid, want.gesture, want.sample_class,
                           rsp_gesture_valid, rsp_gesture, rsp_sample_class);
               end
            end
         end
      end
   end

   // Strict threshold tests, Y before X.
   function automatic gesture_type classify_tilt(input logic signed [SAMPLE_W-1:0] ax,
                                                 input logic signed [SAMPLE_W-1:0] ay);
      int xi;
      int yi;
      int lt;
      int vt;
      xi = int'(ax);
      yi = int'(ay);
      lt = int'(lat_thr);
      vt = int'(vert_thr);
      if (yi > lt) return GST_LEFT;
      if (yi < -lt) return GST_RIGHT;
      if (xi > vt) return GST_UP;
      if (xi < -vt) return GST_DOWN;
      return GST_UNKNOWN;
   endfunction

   // Advance the local state by one accepted sample and queue its result.
   task automatic predict_tilt(input logic signed [SAMPLE_W-1:0] ax,
                               input logic signed [SAMPLE_W-1:0] ay,
                               input logic cons);
      gesture_type     cls;
      logic [1:0]      second;
      logic [1:0]      third;
      tilt_result_type res;
      if (cons) begin
         latch_on  = 1'b0;
         latch_gst = GST_UNKNOWN;
      end
      cls = classify_tilt(ax, ay);
      hist_ptr = hist_ptr + 2'd1;
      cls_hist[hist_ptr] = cls;
      if (!latch_on) begin
         second = hist_ptr - 2'd1;
         third  = hist_ptr - 2'd2;
         if (cls != GST_UNKNOWN) begin
            latch_on  = 1'b1;
            latch_gst = cls;
         end
         // Three equal up or down classes in a row turn into forward or back.
         if (cls_hist[second] == cls && cls_hist[third] == cls &&
             (cls == GST_UP || cls == GST_DOWN)) begin
            latch_on  = 1'b1;
            latch_gst = (cls == GST_UP) ? GST_FORWARD : GST_BACK;
            cls_hist[second] = GST_UNKNOWN;
            cls_hist[third]  = GST_UNKNOWN;
         end
      end
      res.gesture_valid = latch_on;
      res.gesture       = latch_on ? latch_gst : GST_UNKNOWN;
      res.sample_class  = cls;
      expected_results.push_back(res);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Offer one sample, possibly after a random gap, and wait for its transfer.
   // Valid is left high so that a following sample can be offered back to back.
   task automatic send_sample(input int ax, input int ay, input logic cons);
      logic signed [SAMPLE_W-1:0] sx;
      logic signed [SAMPLE_W-1:0] sy;
      int gap;
      sx  = ax[SAMPLE_W-1:0];
      sy  = ay[SAMPLE_W-1:0];
      gap = 0;
      while ($urandom_range(0, 99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_accel_x  <= sx;
      req_accel_y  <= sy;
      req_consumed <= cons;
      do @(posedge clock); while (!req_ready);
      predict_tilt(sx, sy, cons);
   endtask

   // Stop offering samples and wait until every result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One register write; valid stays high for a following write.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [THRESH_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_LATERAL:  lat_thr  = value;
         REG_VERTICAL: vert_thr = value;
         default: ;
      endcase
   endtask

   // Only called while the block is idle. A spare index is written too.
   task automatic program_thresholds(input int lat, input int vert);
      write_csr($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, THRESH_W'($urandom));
      write_csr(REG_LATERAL, THRESH_W'(lat));
      write_csr(REG_VERTICAL, THRESH_W'(vert));
      csr_valid <= 1'b0;
   endtask

   // A value strictly past the threshold on the chosen side.
   function automatic int beyond(input int thr, input bit negative);
      if (negative) return -int'($urandom_range(thr + 1, 32768));
      // Nothing lies above the largest threshold.
      if (thr >= 32767) return 32767;
      return int'($urandom_range(thr + 1, 32767));
   endfunction

   // A value that does not pass the threshold, sometimes exactly on it.
   function automatic int between(input int thr);
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? thr : -thr;
      return int'($urandom_range(0, 2 * thr)) - thr;
   endfunction

   function automatic int any_sample();
      return int'($urandom_range(0, 65535)) - 32768;
   endfunction

   // Random traffic made mostly of runs that aim at one class, with noise mixed in.
   task automatic send_random_items(input int count);
      int          sent;
      int          kind;
      int          run_len;
      int          ax;
      int          ay;
      int          lt;
      int          vt;
      logic        cons;
      gesture_type target;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            target  = $urandom_range(0, 1) ? GST_UP : GST_DOWN;
            run_len = $urandom_range(1, 5);
         end else if (kind < 8) begin
            target  = gesture_type'($urandom_range(0, 2));
            run_len = $urandom_range(1, 2);
         end else begin
            target  = GST_FORWARD;
            run_len = $urandom_range(1, 3);
         end
         for (int i = 0; i < run_len; i++) begin
            lt = int'(lat_thr);
            vt = int'(vert_thr);
            ax = any_sample();
            ay = any_sample();
            cons = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 9) == 0);
            case (target)
               GST_LEFT:  ay = beyond(lt, 1'b0);
               GST_RIGHT: ay = beyond(lt, 1'b1);
               GST_UP: begin
                  ay = between(lt);
                  ax = beyond(vt, 1'b0);
               end
               GST_DOWN: begin
                  ay = between(lt);
                  ax = beyond(vt, 1'b1);
               end
               GST_UNKNOWN: begin
                  ay = between(lt);
                  ax = between(vt);
               end
               // Noise: both axes fully random.
               default: cons = 1'($urandom_range(0, 1));
            endcase
            send_sample(ax, ay, cons);
            sent++;
         end
      end
   endtask

   // Every class and the exact threshold boundaries at the reset thresholds.
   task automatic test_reset_thresholds();
      send_sample(0, 0, 1'b0);
      send_sample(0, 4001, 1'b0);
      send_sample(0, 4000, 1'b1);
      send_sample(0, -4000, 1'b0);
      send_sample(0, -4001, 1'b0);
      send_sample(5001, 0, 1'b1);
      send_sample(5000, 0, 1'b1);
      send_sample(-5000, 0, 1'b1);
      send_sample(-5001, 0, 1'b1);
      send_sample(32767, 32767, 1'b1);
      send_sample(-32768, -32768, 1'b1);
      send_sample(32767, 0, 1'b1);
      send_sample(-32768, 0, 1'b1);
   endtask

   // A held latch ignores new classes until a consumed sample clears it.
   task automatic test_consumed_latch();
      send_sample(0, 4001, 1'b1);
      send_sample(0, -4001, 1'b0);
      send_sample(0, 0, 1'b1);
   endtask

   // Three ups give forward, three downs give back, and the history is cleared after.
   task automatic test_forward_back();
      send_sample(5001, 0, 1'b1);
      send_sample(20000, -3999, 1'b1);
      send_sample(32767, 3999, 1'b1);
      send_sample(-5001, 0, 1'b1);
      send_sample(-32768, 0, 1'b1);
      send_sample(-9000, 100, 1'b1);
      send_sample(5001, 0, 1'b1);
   endtask

   // Both registers at their extremes and at a random middle setting.
   task automatic test_threshold_registers();
      drain_results();
      program_thresholds(0, 0);
      send_random_items(40);
      drain_results();
      program_thresholds(32767, 32767);
      send_random_items(40);
      drain_results();
      program_thresholds($urandom_range(1, 32766), $urandom_range(1, 32766));
      send_random_items(40);
   endtask

   // Bulk random traffic in three flow-control regimes.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         drain_results();
         case (phase)
            0: set_idle(12, 61);
            1: set_idle(61, 12);
            default: set_idle(0, 0);
         endcase
         if ($urandom_range(0, 3) == 0) begin
            program_thresholds($urandom_range(0, 32767), $urandom_range(0, 32767));
         end else begin
            program_thresholds($urandom_range(100, 12000), $urandom_range(100, 12000));
         end
         send_random_items(360);
      end
   endtask

   // The receiver holds off long enough for the block to stall its input.
   task automatic test_backpressure();
      drain_results();
      set_idle(0, 0);
      stall_len = 300;
      stall_requests++;
      send_random_items(60);
      drain_results();
      send_random_items(20);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      set_idle(12, 61);
      test_reset_thresholds();
      test_consumed_latch();
      test_forward_back();
      test_threshold_registers();
      test_random_traffic();
      test_backpressure();
      drain_results();
      if (mismatch_count == 0) begin
         $display("tilt_gesture_classifier test passed");
      end else begin
         $display("tilt_gesture_classifier test failed");
      end
      $finish;
   end

endmodule
